@@ hdl/bgi_pkg.sv @@
// Shared types, constants and arithmetic helpers for the bilinear grid interpolator.
`timescale 1ns / 1ps
package bgi_pkg;

  localparam int DefMaxRows = 64;
  localparam int DefMaxCols = 64;
  localparam int IdxW       = 10;
  localparam int DivStages  = 47;

  localparam logic [1:0] RegStepRadial   = 2'd0;
  localparam logic [1:0] RegStepMomentum = 2'd1;
  localparam logic [1:0] RegRowsUsed     = 2'd2;
  localparam logic [1:0] RegColsUsed     = 2'd3;

  typedef struct packed {
    logic        is_query;
    logic        neg;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] sample;
    logic [30:0] rem_r;
    logic [46:0] nq_r;
    logic [30:0] rem_m;
    logic [46:0] nq_m;
  } div_item_t;

  typedef struct packed {
    logic            is_query;
    logic            oor;
    logic            wr_en;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic [31:0]     sample;
    logic [15:0]     ar;
    logic [15:0]     am;
  } qent_t;

  function automatic logic [77:0] div_bit(input logic [30:0] rem, input logic [46:0] nq,
                                          input logic [30:0] s);
    logic [31:0] t;
    logic [31:0] diff;
    logic        ge;
    t    = {rem, nq[46]};
    diff = t - {1'b0, s};
    ge   = (t >= {1'b0, s});
    div_bit = {(ge ? diff[30:0] : t[30:0]), nq[45:0], ge};
  endfunction

  function automatic div_item_t div_step(input div_item_t it, input logic [30:0] sr,
                                         input logic [30:0] sm);
    div_item_t o;
    o = it;
    {o.rem_r, o.nq_r} = div_bit(it.rem_r, it.nq_r, sr);
    {o.rem_m, o.nq_m} = div_bit(it.rem_m, it.nq_m, sm);
    div_step = o;
  endfunction

endpackage

@@ hdl/bgi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bgi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AW-1:0]          waddr_i,
  input  logic [WIDTH-1:0]       wdata_i,
  input  logic [AW-1:0]          raddr_i,
  output logic [WIDTH-1:0]       rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ hdl/bgi_front.sv @@
// Front part: coordinate division pipeline and query classification.
`timescale 1ns / 1ps
module bgi_front import bgi_pkg::*; #(
  parameter int MAX_ROWS = DefMaxRows,
  parameter int MAX_COLS = DefMaxCols,
  parameter int NRW      = $clog2(MAX_ROWS + 1),
  parameter int NCW      = $clog2(MAX_COLS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic           mode_i,
  input  logic [5:0]     row_i,
  input  logic [5:0]     col_i,
  input  logic [31:0]    sample_i,
  input  logic [31:0]    coord_radial_i,
  input  logic [31:0]    coord_momentum_i,
  input  logic [30:0]    step_r_i,
  input  logic [30:0]    step_m_i,
  input  logic [NRW-1:0] nr_i,
  input  logic [NCW-1:0] nc_i,
  output logic           push_o,
  output qent_t          ent_o
);
  div_item_t st_q [DivStages+1];
  logic      vld_q [DivStages+1];
  div_item_t last;
  logic [30:0] idx_r;
  logic [30:0] idx_m;
  logic        last_r;
  logic        last_m;
  qent_t       ent_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      st_q[0].is_query <= mode_i;
      st_q[0].neg      <= coord_radial_i[31] | coord_momentum_i[31];
      st_q[0].row      <= row_i;
      st_q[0].col      <= col_i;
      st_q[0].sample   <= sample_i;
      st_q[0].rem_r    <= '0;
      st_q[0].nq_r     <= {coord_radial_i[30:0], 16'h0000};
      st_q[0].rem_m    <= '0;
      st_q[0].nq_m     <= {coord_momentum_i[30:0], 16'h0000};
    end
  end

  for (genvar k = 1; k <= DivStages; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      st_q[k] <= div_step(st_q[k-1], step_r_i, step_m_i);
    end
  end

  assign last  = st_q[DivStages];
  assign idx_r = last.nq_r[46:16];
  assign idx_m = last.nq_m[46:16];
  assign last_r = (idx_r == 31'(nr_i) - 31'd1);
  assign last_m = (idx_m == 31'(nc_i) - 31'd1);

  always_comb begin
    ent_d.is_query = last.is_query;
    ent_d.oor      = last.neg || (idx_r >= 31'(nr_i)) || (idx_m >= 31'(nc_i));
    ent_d.wr_en    = (32'(last.row) < 32'(MAX_ROWS)) && (32'(last.col) < 32'(MAX_COLS));
    ent_d.sample   = last.sample;
    ent_d.ar       = last_r ? 16'h0000 : last.nq_r[15:0];
    ent_d.am       = last_m ? 16'h0000 : last.nq_m[15:0];
    if (last.is_query) begin
      ent_d.row = IdxW'(idx_r);
      ent_d.col = IdxW'(idx_m);
    end else begin
      ent_d.row = IdxW'(last.row);
      ent_d.col = IdxW'(last.col);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_o <= 1'b0;
    end else begin
      push_o <= vld_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    ent_o <= ent_d;
  end
endmodule

@@ hdl/bgi_queue.sv @@
// Two-entry queue between the front and back parts.
`timescale 1ns / 1ps
module bgi_queue import bgi_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t ent_i,
  input  logic  pop_i,
  output qent_t head_o,
  output logic  empty_o,
  output logic  full_o
);
  qent_t      mem_q [2];
  logic       wp_q;
  logic       rp_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign head_o  = mem_q[rp_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (do_pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= ent_i;
    end
  end
endmodule

@@ hdl/bgi_back.sv @@
// Back part: banked grid store, corner fetch and the two blend stages.
`timescale 1ns / 1ps
module bgi_back import bgi_pkg::*; #(
  parameter int MAX_ROWS = DefMaxRows,
  parameter int MAX_COLS = DefMaxCols
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        avail_i,
  input  qent_t       ent_i,
  output logic        pop_o,
  output logic        valid_o,
  output logic [31:0] value_o,
  output logic        out_of_range_o
);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int HR = (MAX_ROWS + 1) / 2;
  localparam int HC = (MAX_COLS + 1) / 2;
  localparam int BD = HR * HC;
  localparam int AW = (BD > 1) ? $clog2(BD) : 1;

  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [AW-1:0] raddr [4];
  logic [AW-1:0] waddr;
  logic [31:0]   rdata [4];
  logic          wr_go;

  logic        v1_q, v2_q, v3_q, v4_q;
  logic        o1_q, o2_q, o3_q, o4_q;
  logic [15:0] ar1_q, am1_q, am2_q, am3_q;
  logic        i0_q, j0_q;
  logic [31:0] c00, c01, c10, c11;
  logic [31:0] c00_q, c01_q;
  logic signed [49:0] pb_q, pt_q, p2_q;
  logic [31:0] xb_d, xt_d, xb_q, xt_q, xb4_q;

  assign pop_o = avail_i;
  assign row   = ent_i.row[RW-1:0];
  assign col   = ent_i.col[CW-1:0];
  assign wr_go = avail_i && !ent_i.is_query && ent_i.wr_en;
  assign waddr = AW'(32'(row >> 1) * HC + 32'(col >> 1));

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic PR = b[1];
    localparam logic PC = b[0];
    logic [RW:0] rsum;
    logic [CW:0] csum;
    logic [RW-1:0] rh;
    logic [CW-1:0] ch;

    assign rsum = (RW+1)'(row) + (RW+1)'(PR ^ row[0]);
    assign csum = (CW+1)'(col) + (CW+1)'(PC ^ col[0]);
    assign rh   = rsum[RW:1];
    assign ch   = csum[CW:1];
    assign raddr[b] = ((32'(rh) < HR) && (32'(ch) < HC)) ?
                      AW'(32'(rh) * HC + 32'(ch)) : '0;

    bgi_ram #(.WIDTH(32), .DEPTH(BD)) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_go && (row[0] == PR) && (col[0] == PC)),
      .waddr_i (waddr),
      .wdata_i (ent_i.sample),
      .raddr_i (raddr[b]),
      .rdata_o (rdata[b])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v1_q <= avail_i && ent_i.is_query;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      valid_o <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    o1_q  <= ent_i.oor;
    ar1_q <= ent_i.ar;
    am1_q <= ent_i.am;
    i0_q  <= row[0];
    j0_q  <= col[0];
  end

  always_comb begin
    c00 = rdata[{i0_q, j0_q}];
    c01 = rdata[{i0_q, ~j0_q}];
    c10 = (ar1_q == 16'h0000) ? c00 : rdata[{~i0_q, j0_q}];
    c11 = (ar1_q == 16'h0000) ? c01 : rdata[{~i0_q, ~j0_q}];
  end

  always_ff @(posedge clk_i) begin
    pb_q  <= 50'(($signed({c10[31], c10}) - $signed({c00[31], c00})) *
                 $signed({1'b0, ar1_q}));
    pt_q  <= 50'(($signed({c11[31], c11}) - $signed({c01[31], c01})) *
                 $signed({1'b0, ar1_q}));
    c00_q <= c00;
    c01_q <= c01;
    o2_q  <= o1_q;
    am2_q <= am1_q;
  end

  assign xb_d = c00_q + 32'(pb_q >>> 16);
  assign xt_d = (am2_q == 16'h0000) ? xb_d : c01_q + 32'(pt_q >>> 16);

  always_ff @(posedge clk_i) begin
    xb_q  <= xb_d;
    xt_q  <= xt_d;
    o3_q  <= o2_q;
    am3_q <= am2_q;
  end

  always_ff @(posedge clk_i) begin
    p2_q  <= 50'(($signed({xt_q[31], xt_q}) - $signed({xb_q[31], xb_q})) *
                 $signed({1'b0, am3_q}));
    xb4_q <= xb_q;
    o4_q  <= o3_q;
  end

  always_ff @(posedge clk_i) begin
    value_o        <= o4_q ? 32'h0 : xb4_q + 32'(p2_q >>> 16);
    out_of_range_o <= o4_q;
  end
endmodule

@@ hdl/bilinear_grid_interpolator.sv @@
// Top level of the bilinear grid interpolator with its register file.
// Throughput: one transaction per cycle while busy is low; the two
// 47-stage dividers and four RAM banks (one per corner parity) allow
// each cycle a new query or grid load.
// Reset clears the control state and loads the register defaults; grid contents are
// undefined until written. Results cannot be held off by the receiver.
`timescale 1ns / 1ps
module bilinear_grid_interpolator import bgi_pkg::*; #(
  parameter int MAX_ROWS = DefMaxRows,
  parameter int MAX_COLS = DefMaxCols
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [5:0]  row_i,
  input  logic [5:0]  col_i,
  input  logic [31:0] sample_i,
  input  logic [31:0] coord_radial_i,
  input  logic [31:0] coord_momentum_i,
  output logic        valid_o,
  output logic [31:0] value_o,
  output logic        out_of_range_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int NRW = $clog2(MAX_ROWS + 1);
  localparam int NCW = $clog2(MAX_COLS + 1);

  logic [30:0] step_r_q, step_m_q;
  logic [6:0]  rows_q, cols_q;
  logic [30:0] step_r, step_m;
  logic [NRW-1:0] nr;
  logic [NCW-1:0] nc;
  logic  wr;
  logic  accept;
  logic  push;
  qent_t ent;
  qent_t head;
  logic  empty;
  logic  pop;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_r_q <= 31'd65536;
      step_m_q <= 31'd65536;
      rows_q   <= 7'd64;
      cols_q   <= 7'd64;
    end else if (wr) begin
      case (paddr[3:2])
        RegStepRadial:   step_r_q <= pwdata[30:0];
        RegStepMomentum: step_m_q <= pwdata[30:0];
        RegRowsUsed:     rows_q   <= pwdata[6:0];
        RegColsUsed:     cols_q   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegStepRadial:   prdata = {1'b0, step_r_q};
      RegStepMomentum: prdata = {1'b0, step_m_q};
      RegRowsUsed:     prdata = {25'h0, rows_q};
      RegColsUsed:     prdata = {25'h0, cols_q};
      default:         prdata = 32'h0;
    endcase
  end

  assign step_r = (step_r_q == 31'd0) ? 31'd1 : step_r_q;
  assign step_m = (step_m_q == 31'd0) ? 31'd1 : step_m_q;

  always_comb begin
    if (rows_q == 7'd0) begin
      nr = NRW'(1);
    end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
      nr = NRW'(MAX_ROWS);
    end else begin
      nr = NRW'(rows_q);
    end
    if (cols_q == 7'd0) begin
      nc = NCW'(1);
    end else if (32'(cols_q) > 32'(MAX_COLS)) begin
      nc = NCW'(MAX_COLS);
    end else begin
      nc = NCW'(cols_q);
    end
  end

  bgi_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .NRW(NRW), .NCW(NCW)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .mode_i           (mode_i),
    .row_i            (row_i),
    .col_i            (col_i),
    .sample_i         (sample_i),
    .coord_radial_i   (coord_radial_i),
    .coord_momentum_i (coord_momentum_i),
    .step_r_i         (step_r),
    .step_m_i         (step_m),
    .nr_i             (nr),
    .nc_i             (nc),
    .push_o           (push),
    .ent_o            (ent)
  );

  bgi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (ent),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (busy)
  );

  bgi_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .avail_i        (!empty),
    .ent_i          (head),
    .pop_o          (pop),
    .valid_o        (valid_o),
    .value_o        (value_o),
    .out_of_range_o (out_of_range_o)
  );
endmodule

@@ hdl/bgi_checker.sv @@
// Port-level checker for the bilinear grid interpolator, bound to the top level.
`timescale 1ns / 1ps
module bgi_checker import bgi_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        valid_o,
  input logic [31:0] value_o,
  input logic        out_of_range_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && out_of_range_o) |-> (value_o == 32'h0))
    else $error("Out-of-range result with non-zero value.");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("Queue filled although the back part drains every cycle.");

  a_step_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr[3:2] == RegStepRadial)
    |=> (paddr[3:2] != RegStepRadial || prdata == {1'b0, $past(pwdata[30:0])}))
    else $error("Radial step register read-back mismatch.");

  a_rows_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr[3:2] == RegRowsUsed)
    |=> (paddr[3:2] != RegRowsUsed || prdata == {25'h0, $past(pwdata[6:0])}))
    else $error("Row count register read-back mismatch.");
endmodule

bind bilinear_grid_interpolator bgi_checker u_bgi_checker (.*);

@@ sim/bilinear_grid_interpolator_tb.sv @@
// Self-checking testbench for the bilinear grid interpolator: directed and random loads and queries.
`timescale 1ns / 1ps
module bilinear_grid_interpolator_tb;
  import bgi_pkg::*;

  localparam bit ModeLoad  = 1'b0;
  localparam bit ModeQuery = 1'b1;
  localparam int Settle    = 70;

  typedef struct {
    bit signed [31:0] value;
    bit               oor;
  } interp_result_t;

  class interp_scoreboard;
    bit signed [31:0] grid [64][64];
    bit               written [64][64];
    bit [30:0]        step_r = 31'd65536;
    bit [30:0]        step_m = 31'd65536;
    bit [6:0]         rows   = 7'd64;
    bit [6:0]         cols   = 7'd64;
    interp_result_t   pending [$];
    int               errors = 0;

    function void set_reg(logic [1:0] idx, bit [31:0] val);
      case (idx)
        RegStepRadial:   step_r = val[30:0];
        RegStepMomentum: step_m = val[30:0];
        RegRowsUsed:     rows   = val[6:0];
        default:         cols   = val[6:0];
      endcase
    endfunction

    function int clamp_used(bit [6:0] v);
      if (v == 0) return 1;
      if (v > 64) return 64;
      return v;
    endfunction

    function bit split(bit [31:0] c, bit [30:0] st, output longint unsigned idx,
                       output bit [15:0] fr);
      longint unsigned s;
      longint unsigned u;
      longint unsigned r;
      s   = (st == 0) ? 1 : st;
      idx = 0;
      fr  = 0;
      if (c[31]) return 0;
      u   = c;
      idx = u / s;
      r   = u - idx * s;
      fr  = 16'((r << 16) / s);
      return 1;
    endfunction

    function bit reads_written(bit [31:0] cr, bit [31:0] cm);
      longint unsigned i;
      longint unsigned j;
      longint unsigned i1;
      longint unsigned j1;
      bit [15:0]       ar;
      bit [15:0]       am;
      int              nr;
      int              nc;
      nr = clamp_used(rows);
      nc = clamp_used(cols);
      if (!split(cr, step_r, i, ar) || !split(cm, step_m, j, am)) return 1;
      if (i >= nr || j >= nc) return 1;
      i1 = (i < nr - 1) ? i + 1 : i;
      j1 = (j < nc - 1) ? j + 1 : j;
      return written[i][j] && written[i1][j] && written[i][j1] && written[i1][j1];
    endfunction

    function longint blend(longint x0, longint x1, bit [15:0] a);
      longint p;
      p = (x1 - x0) * longint'({48'd0, a});
      return x0 + (p >>> 16);
    endfunction

    function longint corner(longint unsigned i, longint unsigned j);
      return longint'(grid[i][j]);
    endfunction

    function void note_item(bit mode, bit [5:0] row, bit [5:0] col, bit [31:0] sample,
                            bit [31:0] cr, bit [31:0] cm);
      interp_result_t   res;
      longint unsigned  i;
      longint unsigned  j;
      bit [15:0]        ar;
      bit [15:0]        am;
      int               nr;
      int               nc;
      bit               ok_r;
      bit               ok_m;
      longint           x;
      if (mode == ModeLoad) begin
        grid[row][col]    = sample;
        written[row][col] = 1'b1;
        return;
      end
      nr   = clamp_used(rows);
      nc   = clamp_used(cols);
      ok_r = split(cr, step_r, i, ar);
      ok_m = split(cm, step_m, j, am);
      if (!ok_r || !ok_m || i >= nr || j >= nc) begin
        res.value = 0;
        res.oor   = 1;
      end else begin
        if (i < nr - 1 && j < nc - 1)
          x = blend(blend(corner(i, j), corner(i + 1, j), ar),
                    blend(corner(i, j + 1), corner(i + 1, j + 1), ar), am);
        else if (j < nc - 1)
          x = blend(corner(i, j), corner(i, j + 1), am);
        else if (i < nr - 1)
          x = blend(corner(i, j), corner(i + 1, j), ar);
        else
          x = corner(i, j);
        res.value = x[31:0];
        res.oor   = 0;
      end
      pending.push_back(res);
    endfunction

    function void check_result(bit [31:0] value, bit oor);
      interp_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value %h oor %b", $time, value, oor);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.value != value) begin
        $display("%0t: value expected %h actual %h", $time, e.value, value);
        errors++;
      end
      if (e.oor != oor) begin
        $display("%0t: out_of_range expected %b actual %b", $time, e.oor, oor);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        mode_i;
  logic [5:0]  row_i;
  logic [5:0]  col_i;
  logic [31:0] sample_i;
  logic [31:0] coord_radial_i;
  logic [31:0] coord_momentum_i;
  logic        valid_o;
  logic [31:0] value_o;
  logic        out_of_range_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  interp_scoreboard sb = new();
  bit               no_gaps;

  bilinear_grid_interpolator dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .row_i, .col_i, .sample_i,
    .coord_radial_i, .coord_momentum_i, .valid_o, .value_o, .out_of_range_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(value_o, out_of_range_o);
  end

  function int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(bit mode, bit [5:0] row, bit [5:0] col, bit [31:0] sample,
                           bit [31:0] cr, bit [31:0] cm, bit gapped);
    int gap;
    start            <= 1'b1;
    mode_i           <= mode;
    row_i            <= row;
    col_i            <= col;
    sample_i         <= sample;
    coord_radial_i   <= cr;
    coord_momentum_i <= cm;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(mode, row, col, sample, cr, cm);
    gap = gapped ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, bit [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(bit [30:0] sr, bit [30:0] sm, bit [6:0] nr, bit [6:0] nc);
    drain();
    reg_write(RegStepRadial, 32'(sr));
    reg_write(RegStepMomentum, 32'(sm));
    reg_write(RegRowsUsed, 32'(nr));
    reg_write(RegColsUsed, 32'(nc));
    @(posedge clk_i);
  endtask

  function bit [31:0] make_coord(bit [30:0] st, int n);
    longint unsigned s;
    longint unsigned c;
    int              r;
    s = (st == 0) ? 1 : st;
    r = $urandom_range(0, 99);
    if (r < 20) return $urandom;
    if (r < 35) c = (n - 1) * s + $urandom_range(0, s - 1);
    else c = $urandom_range(0, n) * s + $urandom_range(0, s - 1);
    if (c > 64'h7fff_ffff) return $urandom & 32'h7fff_ffff;
    return c[31:0];
  endfunction

  task automatic random_items(int count);
    int        n_r;
    int        n_c;
    bit [31:0] cr;
    bit [31:0] cm;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      n_r = sb.clamp_used(sb.rows);
      n_c = sb.clamp_used(sb.cols);
      if ($urandom_range(0, 3) == 0) begin
        send_item(ModeLoad, 6'($urandom), 6'($urandom), $urandom, $urandom, $urandom,
                  1'b1);
      end else begin
        cr = 32'hffff_ffff;
        cm = 32'h0000_0000;
        for (int t = 0; t < 20; t++) begin
          cr = make_coord(sb.step_r, n_r);
          cm = make_coord(sb.step_m, n_c);
          if (sb.reads_written(cr, cm)) break;
          cr = 32'hffff_ffff;
        end
        send_item(ModeQuery, 6'($urandom), 6'($urandom), $urandom, cr, cm, 1'b1);
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni           <= 1'b0;
    start            <= 1'b0;
    mode_i           <= ModeLoad;
    row_i            <= '0;
    col_i            <= '0;
    sample_i         <= '0;
    coord_radial_i   <= '0;
    coord_momentum_i <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    no_gaps          = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two corner blocks are written first; a query that would read any other
    // unwritten entry is replaced by one with a negative coordinate.
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++) begin
        send_item(ModeLoad, 6'(r), 6'(c), $urandom, '0, '0, 1'b0);
        send_item(ModeLoad, 6'(56 + r), 6'(56 + c), $urandom, '0, '0, 1'b0);
      end

    send_item(ModeLoad, 6'd0, 6'd0, 32'h7fff_ffff, '0, '0, 1'b0);
    send_item(ModeLoad, 6'd1, 6'd0, 32'h8000_0000, '0, '0, 1'b0);
    send_item(ModeLoad, 6'd0, 6'd1, 32'h8000_0000, '0, '0, 1'b0);
    send_item(ModeLoad, 6'd1, 6'd1, 32'h7fff_ffff, '0, '0, 1'b0);
    send_item(ModeLoad, 6'd63, 6'd63, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send_item(ModeQuery, '0, '0, '0, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_item(ModeQuery, '0, '0, '0, 32'h0000_ffff, 32'h0000_ffff, 1'b1);
    send_item(ModeQuery, '0, '0, '0, 32'h0000_8000, 32'h0000_4000, 1'b1);
    send_item(ModeQuery, '0, '0, '0, 32'h003f_8000, 32'h003a_3456, 1'b1);
    send_item(ModeQuery, '0, '0, '0, 32'h003a_3456, 32'h003f_8000, 1'b1);
    send_item(ModeQuery, '0, '0, '0, 32'h003f_ffff, 32'h003f_ffff, 1'b1);
    send_item(ModeQuery, '0, '0, '0, 32'hffff_ffff, 32'h0001_0000, 1'b1);
    send_item(ModeQuery, '0, '0, '0, 32'h0001_0000, 32'h8000_0000, 1'b1);
    send_item(ModeQuery, '0, '0, '0, 32'h0040_0000, 32'h0000_0000, 1'b1);
    send_item(ModeQuery, '0, '0, '0, 32'h0000_0000, 32'h0040_0000, 1'b1);
    send_item(ModeQuery, '0, '0, '0, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);

    random_items(60);
    configure(31'd1, 31'd1, 7'd1, 7'd1);
    send_item(ModeQuery, '0, '0, '0, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_item(ModeQuery, '0, '0, '0, 32'h0000_0001, 32'h0000_0000, 1'b1);
    random_items(40);
    configure(31'h7fff_ffff, 31'h7fff_ffff, 7'd64, 7'd64);
    send_item(ModeQuery, '0, '0, '0, 32'h7fff_fffe, 32'h7fff_fffe, 1'b1);
    random_items(60);
    configure(31'h0001_8000, 31'h0000_9000, 7'd5, 7'd7);
    random_items(80);
    configure(31'd3, 31'h0100_0000, 7'd64, 7'd2);
    random_items(60);
    for (int p = 0; p < 2; p++) begin
      configure(31'($urandom_range(1, 32'h0004_0000)), 31'($urandom_range(1, 32'h0004_0000)),
                7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
      random_items(60);
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("bilinear_grid_interpolator_tb: done, clean");
    end else begin
      $display("bilinear_grid_interpolator_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("bilinear_grid_interpolator_tb: done, errors");
    $finish;
  end

endmodule
